@@ src/pdnf_pkg.sv @@
package pdnf_pkg;

   localparam int COORD_W   = 16;
   localparam int DIST_W    = 16;
   localparam int SQ_W      = 32;
   localparam int REM_W     = DIST_W + 3;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int TOTAL_W   = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   localparam logic [OP_W-1:0] OP_PUSH_TOP    = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_TOP     = 3'd1;
   localparam logic [OP_W-1:0] OP_PUSH_BOTTOM = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BOTTOM  = 3'd3;
   localparam logic [OP_W-1:0] OP_LENGTH      = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;
   localparam logic [OP_W-1:0] OP_FARTHEST    = 3'd6;
   localparam logic [OP_W-1:0] OP_NEAREST     = 3'd7;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DIST_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_HIGH = 1'b1;

   localparam logic [CSR_W-1:0] DIST_LOW_RESET  = 16'd0;
   localparam logic [CSR_W-1:0] DIST_HIGH_RESET = 16'd100;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [DIST_W-1:0]         distance;
   } point_rec_type;

   typedef struct packed {
      logic                      start;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } dist_request_type;

   typedef struct packed {
      logic              done;
      logic [DIST_W-1:0] distance;
   } dist_result_type;

endpackage

@@ src/pdnf_dist.sv @@
module pdnf_dist (
   input  logic                       clock,
   input  logic                       reset,
   input  pdnf_pkg::dist_request_type dist_req,
   output pdnf_pkg::dist_result_type  dist_res
);
   import pdnf_pkg::*;

   localparam int STEP_W = $clog2(DIST_W);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_SQUARE = 2'd1;
   localparam logic [1:0] PH_ROOT   = 2'd2;

   localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(3);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(DIST_W - 1);

   logic [1:0]        phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;
   logic [SQ_W-1:0]   prod_ff, prod_in;
   logic [SQ_W-1:0]   acc_ff, acc_in;
   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIST_W-1:0] root_ff, root_in;

   logic signed [COORD_W-1:0] mult_op;
   logic signed [SQ_W-1:0]    square;
   logic [REM_W-1:0]          rem_shift;
   logic [REM_W-1:0]          trial;

   // one multiplier squares x, y and z in turn
   always_comb begin
      case (step_ff[1:0])
         2'd0:    mult_op = dist_req.x;
         2'd1:    mult_op = dist_req.y;
         default: mult_op = dist_req.z;
      endcase
   end

   assign square    = mult_op * mult_op;
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[SQ_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (dist_req.start) begin
               acc_in   = '0;
               step_in  = '0;
               phase_in = PH_SQUARE;
            end
         end
         PH_SQUARE: begin
            prod_in = unsigned'(square);
            // product of the previous step is not valid on the first step
            if (step_ff != '0) begin
               acc_in = acc_ff + prod_ff;
            end
            if (step_ff == SQ_LAST) begin
               rad_in   = acc_ff + prod_ff;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               phase_in = PH_ROOT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         PH_ROOT: begin
            // one result bit per cycle, two radicand bits brought down
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[DIST_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[DIST_W-2:0], 1'b0};
            end
            rad_in  = {rad_ff[SQ_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == ROOT_LAST) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign dist_res.done     = done_ff;
   assign dist_res.distance = root_ff;

endmodule

@@ src/point_deque_nearest_farthest_core.sv @@
// Bounded deque of 3D points with a windowed nearest / farthest search.
// Input channel req_*: opcode and a point; a transfer happens when req_valid
// is high and req_stall is low. Result channel rsp_*: one result per input,
// taken when rsp_valid is high and rsp_stall is low. Configuration port csr_*
// writes the two distance bounds; csr_ready is always high and writes belong
// in idle periods.
// One item is in flight at a time; req_stall stays high until its result has
// been loaded into the output register. Work per request:
//   push:  squaring on the shared multiplier, 16 square root iterations,
//          then result handoff, store and output load
//   pop:   registered memory read
//   search: one entry per cycle
//   length, clear, push when full, pop when empty: straight to the output load
// The next transfer can happen in the cycle that rsp_valid rises, even if
// that result is still stalled; the following result then waits for the
// output register to drain. Reset empties the deque, sets the bounds to 0
// and 100 and drops any pending result. Point storage is not cleared.
module point_deque_nearest_farthest_core #(
   parameter int CAPACITY = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [pdnf_pkg::OP_W-1:0]               req_opcode,
   input  logic signed [pdnf_pkg::COORD_W-1:0]     req_coord_x,
   input  logic signed [pdnf_pkg::COORD_W-1:0]     req_coord_y,
   input  logic signed [pdnf_pkg::COORD_W-1:0]     req_coord_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [pdnf_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [pdnf_pkg::COORD_W-1:0]     rsp_out_x,
   output logic signed [pdnf_pkg::COORD_W-1:0]     rsp_out_y,
   output logic signed [pdnf_pkg::COORD_W-1:0]     rsp_out_z,
   output logic [pdnf_pkg::DIST_W-1:0]             rsp_out_distance,
   output logic [pdnf_pkg::TOTAL_W-1:0]            rsp_entry_total,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pdnf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pdnf_pkg::CSR_W-1:0]              csr_data
);
   import pdnf_pkg::*;

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);
   localparam logic [SUM_W-1:0] SUM_CAP    = SUM_W'(CAPACITY);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIST = 3'd1;
   localparam logic [2:0] ST_POPA = 3'd2;
   localparam logic [2:0] ST_POPB = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_SLOT : p - 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] w;
      w = (s >= SUM_CAP) ? s - SUM_CAP : s;
      return w[PTR_W-1:0];
   endfunction

   logic [2:0]                state_ff, state_in;
   logic [OP_W-1:0]           op_ff, op_in;
   logic signed [COORD_W-1:0] x_ff, x_in;
   logic signed [COORD_W-1:0] y_ff, y_in;
   logic signed [COORD_W-1:0] z_ff, z_in;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic [PTR_W-1:0]          bottom_ff, bottom_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          left_ff, left_in;
   logic                      pend_ff, pend_in;
   logic                      found_ff, found_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   point_rec_type             res_rec_ff, res_rec_in;
   logic [CSR_W-1:0]          dist_low_ff;
   logic [CSR_W-1:0]          dist_high_ff;

   point_rec_type             point_mem_ff [CAPACITY];
   point_rec_type             rd_data_ff;
   point_rec_type             wr_rec;
   logic                      mem_wr;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   point_rec_type             rsp_rec_ff;
   logic [TOTAL_W-1:0]        rsp_total_ff;
   logic                      rsp_load;

   logic                      req_xfer;
   logic [SUM_W-1:0]          sum_push;
   logic [SUM_W-1:0]          sum_pop;
   logic                      qualifies;
   logic                      better;
   logic [TOTAL_W+CNT_W-1:0]  total_ext;

   dist_request_type          dist_req;
   dist_result_type           dist_res;

   pdnf_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .dist_req (dist_req),
      .dist_res (dist_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign sum_push = SUM_W'(bottom_ff) + SUM_W'(count_ff);
   assign sum_pop  = sum_push - 1'b1;

   assign qualifies = (rd_data_ff.distance > dist_low_ff) &&
                      (rd_data_ff.distance < dist_high_ff);
   assign better    = !found_ff ||
                      ((op_ff == OP_FARTHEST) && (rd_data_ff.distance > res_rec_ff.distance)) ||
                      ((op_ff == OP_NEAREST) && (rd_data_ff.distance < res_rec_ff.distance));

   assign dist_req.start = req_xfer && (count_ff != FULL_COUNT) &&
                           ((req_opcode == OP_PUSH_TOP) || (req_opcode == OP_PUSH_BOTTOM));
   assign dist_req.x = x_ff;
   assign dist_req.y = y_ff;
   assign dist_req.z = z_ff;

   assign wr_rec.x        = x_ff;
   assign wr_rec.y        = y_ff;
   assign wr_rec.z        = z_ff;
   assign wr_rec.distance = dist_res.distance;

   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      ptr_in        = ptr_ff;
      bottom_in     = bottom_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_rec_in    = res_rec_ff;
      mem_wr        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in         = req_opcode;
               x_in          = req_coord_x;
               y_in          = req_coord_y;
               z_in          = req_coord_z;
               res_status_in = STAT_OK;
               res_rec_in    = '0;
               unique case (req_opcode) inside
                  OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
                     if (count_ff == FULL_COUNT) begin
                        res_status_in = STAT_FULL;
                        state_in      = ST_EMIT;
                     end else begin
                        count_in = count_ff + 1'b1;
                        if (req_opcode == OP_PUSH_TOP) begin
                           ptr_in = ring_wrap(sum_push);
                        end else begin
                           bottom_in = ring_prev(bottom_ff);
                           ptr_in    = ring_prev(bottom_ff);
                        end
                        state_in = ST_DIST;
                     end
                  end
                  OP_POP_TOP, OP_POP_BOTTOM: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_EMPTY;
                        state_in      = ST_EMIT;
                     end else begin
                        count_in = count_ff - 1'b1;
                        if (req_opcode == OP_POP_TOP) begin
                           ptr_in = ring_wrap(sum_pop);
                        end else begin
                           ptr_in    = bottom_ff;
                           bottom_in = ring_next(bottom_ff);
                        end
                        state_in = ST_POPA;
                     end
                  end
                  OP_LENGTH: begin
                     state_in = ST_EMIT;
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     bottom_in = '0;
                     state_in  = ST_EMIT;
                  end
                  OP_FARTHEST, OP_NEAREST: begin
                     ptr_in   = bottom_ff;
                     left_in  = count_ff;
                     pend_in  = 1'b0;
                     found_in = 1'b0;
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_DIST: begin
            if (dist_res.done) begin
               mem_wr              = 1'b1;
               res_rec_in.distance = dist_res.distance;
               state_in            = ST_EMIT;
            end
         end
         ST_POPA: begin
            state_in = ST_POPB;
         end
         ST_POPB: begin
            res_rec_in = rd_data_ff;
            state_in   = ST_EMIT;
         end
         ST_SCAN: begin
            // issue one read per cycle; its data is compared in the next cycle
            if (left_ff != '0) begin
               ptr_in  = ring_next(ptr_ff);
               left_in = left_ff - 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && qualifies && better) begin
               res_rec_in = rd_data_ff;
               found_in   = 1'b1;
            end
            if ((left_ff == '0) && !pend_ff) begin
               if (!found_ff) begin
                  res_status_in = STAT_NONE;
                  res_rec_in    = '0;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         bottom_ff <= '0;
         count_ff  <= '0;
         left_ff   <= '0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bottom_ff <= bottom_in;
         count_ff  <= count_in;
         left_ff   <= left_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_rec_ff    <= res_rec_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         point_mem_ff[ptr_ff] <= wr_rec;
      end
      rd_data_ff <= point_mem_ff[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_low_ff  <= DIST_LOW_RESET;
         dist_high_ff <= DIST_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DIST_LOW:  dist_low_ff  <= csr_data;
            CSR_DIST_HIGH: dist_high_ff <= csr_data;
         endcase
      end
   end

   assign total_ext = {TOTAL_W'(0), count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_rec_ff    <= res_rec_ff;
         rsp_total_ff  <= total_ext[TOTAL_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_x        = rsp_rec_ff.x;
   assign rsp_out_y        = rsp_rec_ff.y;
   assign rsp_out_z        = rsp_rec_ff.z;
   assign rsp_out_distance = rsp_rec_ff.distance;
   assign rsp_entry_total  = rsp_total_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds capacity");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result presented without a finished item");

   a_dist_done_in_dist: assert property (@(posedge clock) disable iff (reset)
      dist_res.done |-> (state_ff == ST_DIST))
      else $error("distance unit finished outside a push");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SCAN))
      else $error("scan read pending outside a search");
`endif

endmodule

@@ bench/point_deque_nearest_farthest_core_test.sv @@
`timescale 1ns / 1ps

module point_deque_nearest_farthest_core_test;
   import pdnf_pkg::*;

   localparam int          DEPTH       = 16;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned ITEMS_PER_PHASE = 86;

   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic [OP_W-1:0]            req_opcode  = OP_LENGTH;
   logic signed [COORD_W-1:0]  req_coord_x = '0;
   logic signed [COORD_W-1:0]  req_coord_y = '0;
   logic signed [COORD_W-1:0]  req_coord_z = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [COORD_W-1:0]  rsp_out_x;
   logic signed [COORD_W-1:0]  rsp_out_y;
   logic signed [COORD_W-1:0]  rsp_out_z;
   logic [DIST_W-1:0]          rsp_out_distance;
   logic [TOTAL_W-1:0]         rsp_entry_total;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index   = CSR_DIST_LOW;
   logic [CSR_W-1:0]           csr_data    = '0;

   typedef struct {
      logic [STATUS_W-1:0]       status;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [DIST_W-1:0]         distance;
      logic [TOTAL_W-1:0]        total;
   } deque_reply_type;

   class deque_tracker;
      point_rec_type    slots[DEPTH];
      int unsigned      bottom;
      int unsigned      count;
      logic [CSR_W-1:0] low_bound;
      logic [CSR_W-1:0] high_bound;
      deque_reply_type  pending_replies[$];
      int unsigned      fail_count;

      function new();
         bottom     = 0;
         count      = 0;
         low_bound  = DIST_LOW_RESET;
         high_bound = DIST_HIGH_RESET;
         fail_count = 0;
      endfunction

      function void set_bound(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
         if (idx == CSR_DIST_LOW) begin
            low_bound = value;
         end else begin
            high_bound = value;
         end
      endfunction

      function logic [DIST_W-1:0] floor_root(input longint unsigned sq);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 16; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq) begin
               root = trial;
            end
         end
         return root[DIST_W-1:0];
      endfunction

      function void note_request(input logic [OP_W-1:0] op, input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y,
                                 input logic signed [COORD_W-1:0] z);
         deque_reply_type   r;
         point_rec_type     p;
         int unsigned       slot;
         int unsigned       best;
         logic              found;
         logic [DIST_W-1:0] d;
         longint            sq;
         r = '{default: '0};
         r.status = STAT_OK;
         case (op)
            OP_PUSH_TOP, OP_PUSH_BOTTOM: begin
               if (count >= DEPTH) begin
                  r.status = STAT_FULL;
               end else begin
                  sq = longint'(x) * longint'(x) + longint'(y) * longint'(y)
                       + longint'(z) * longint'(z);
                  p.x        = x;
                  p.y        = y;
                  p.z        = z;
                  p.distance = floor_root(sq);
                  if (op == OP_PUSH_TOP) begin
                     slot = (bottom + count) % DEPTH;
                  end else begin
                     bottom = (bottom + DEPTH - 1) % DEPTH;
                     slot   = bottom;
                  end
                  slots[slot] = p;
                  count++;
                  r.distance = p.distance;
               end
            end
            OP_POP_TOP, OP_POP_BOTTOM: begin
               if (count == 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  if (op == OP_POP_TOP) begin
                     slot = (bottom + count - 1) % DEPTH;
                  end else begin
                     slot   = bottom;
                     bottom = (bottom + 1) % DEPTH;
                  end
                  r.x        = slots[slot].x;
                  r.y        = slots[slot].y;
                  r.z        = slots[slot].z;
                  r.distance = slots[slot].distance;
                  count--;
               end
            end
            OP_LENGTH: ;
            OP_CLEAR: begin
               count  = 0;
               bottom = 0;
            end
            default: begin
               // scan bottom to top; strict compare keeps the first of a tie
               found = 1'b0;
               best  = 0;
               for (int unsigned i = 0; i < count; i++) begin
                  slot = (bottom + i) % DEPTH;
                  d    = slots[slot].distance;
                  if (d <= low_bound || d >= high_bound) continue;
                  if (!found || (op == OP_FARTHEST && d > slots[best].distance)
                      || (op == OP_NEAREST && d < slots[best].distance)) begin
                     found = 1'b1;
                     best  = slot;
                  end
               end
               if (found) begin
                  r.x        = slots[best].x;
                  r.y        = slots[best].y;
                  r.z        = slots[best].z;
                  r.distance = slots[best].distance;
               end else begin
                  r.status = STAT_NONE;
               end
            end
         endcase
         r.total = count[TOTAL_W-1:0];
         pending_replies.push_back(r);
      endfunction

      function void compare_field(input string name, input longint want, input longint seen);
         if (want != seen) begin
            $error("%s expected %0d actual %0d", name, want, seen);
            fail_count++;
         end
      endfunction

      function void check_result(input deque_reply_type got);
         deque_reply_type want;
         if (pending_replies.size() == 0) begin
            $error("result transfer with no request outstanding");
            fail_count++;
            return;
         end
         want = pending_replies.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("out_x", want.x, got.x);
         compare_field("out_y", want.y, got.y);
         compare_field("out_z", want.z, got.z);
         compare_field("out_distance", want.distance, got.distance);
         compare_field("entry_total", want.total, got.total);
      endfunction

      function int unsigned outstanding();
         return pending_replies.size();
      endfunction
   endclass

   deque_tracker tracker;

   point_deque_nearest_farthest_core #(.CAPACITY(DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_distance (rsp_out_distance),
      .rsp_entry_total  (rsp_entry_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // values read right after the edge are the ones the block sampled
   always @(posedge clock) begin
      deque_reply_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status   = rsp_status;
         got.x        = rsp_out_x;
         got.y        = rsp_out_y;
         got.z        = rsp_out_z;
         got.distance = rsp_out_distance;
         got.total    = rsp_entry_total;
         tracker.check_result(got);
      end
   end

   initial begin : stall_pattern
      int unsigned seg;
      int unsigned span;
      int unsigned style;
      seg = 0;
      while (reset) @(posedge clock);
      forever begin
         seg++;
         if (seg == 8 || $urandom_range(99) == 0) begin
            // long hold: the block fills and must push back on its input
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else begin
            span  = $urandom_range(40, 1);
            style = $urandom_range(3);
            for (int unsigned n = 0; n < span; n++) begin
               case (style)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(1) == 1);
                  2: rsp_stall <= (n % 3 == 0);
                  default: rsp_stall <= ($urandom_range(3) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("point_deque_nearest_farthest_core_test: errors");
      $finish;
   end

   // called at a rising edge; returns at the edge of the transfer, valid left high
   task automatic offer_op(input logic [OP_W-1:0] op, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z);
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, x, y, z);
   endtask

   task automatic drain_and_wait(input int unsigned tail);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_bounds(input logic [CSR_W-1:0] low_val, input logic [CSR_W-1:0] high_val);
      logic [CSR_IDX_W-1:0] idx;
      for (int k = 0; k < 2; k++) begin
         idx = (k == 0) ? CSR_DIST_LOW : CSR_DIST_HIGH;
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= (k == 0) ? low_val : high_val;
         do @(posedge clock); while (!csr_ready);
         tracker.set_bound(idx, (k == 0) ? low_val : high_val);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord();
      int v;
      case ($urandom_range(3))
         0, 1: v = int'($urandom_range(160)) - 80;
         2: v = int'($urandom_range(3000)) - 1500;
         default: v = int'($urandom());
      endcase
      return v[COORD_W-1:0];
   endfunction

   // mode 0 balanced, 1 fill, 2 drain
   function automatic logic [OP_W-1:0] pick_op(input int unsigned mode);
      int unsigned r;
      logic [OP_W-1:0] push_op;
      logic [OP_W-1:0] pop_op;
      logic [OP_W-1:0] find_op;
      r       = $urandom_range(99);
      push_op = $urandom_range(1) ? OP_PUSH_TOP : OP_PUSH_BOTTOM;
      pop_op  = $urandom_range(1) ? OP_POP_TOP : OP_POP_BOTTOM;
      find_op = $urandom_range(1) ? OP_FARTHEST : OP_NEAREST;
      if (mode == 1) begin
         return (r < 90) ? push_op : (r < 96) ? find_op : OP_LENGTH;
      end else if (mode == 2) begin
         return (r < 55) ? pop_op : (r < 75) ? push_op : (r < 92) ? find_op
              : (r < 96) ? OP_LENGTH : OP_CLEAR;
      end
      return (r < 40) ? push_op : (r < 62) ? pop_op : (r < 90) ? find_op
           : (r < 96) ? OP_LENGTH : OP_CLEAR;
   endfunction

   task automatic run_mix(input int unsigned n_items);
      int unsigned burst;
      int unsigned gap;
      int unsigned mode;
      burst = 0;
      mode  = 1;
      for (int unsigned k = 0; k < n_items; k++) begin
         if (k % 20 == 0 && k != 0) mode = $urandom_range(2);
         if (burst == 0) begin
            burst = $urandom_range(12, 1);
            gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 1);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst--;
         offer_op(pick_op(mode), rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   task automatic run_directed();
      offer_op(OP_NEAREST, 0, 0, 0);
      offer_op(OP_POP_TOP, 0, 0, 0);
      offer_op(OP_POP_BOTTOM, 0, 0, 0);
      offer_op(OP_LENGTH, 0, 0, 0);
      offer_op(OP_PUSH_TOP, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      offer_op(OP_PUSH_TOP, -16'sh8000, -16'sh8000, -16'sh8000);
      offer_op(OP_PUSH_BOTTOM, 0, 0, 0);
      offer_op(OP_PUSH_BOTTOM, 3, 4, 0);
      offer_op(OP_PUSH_TOP, 0, 5, 0);
      offer_op(OP_PUSH_TOP, 60, 80, 0);     // on the upper bound: excluded
      offer_op(OP_PUSH_BOTTOM, 0, 0, 99);
      offer_op(OP_PUSH_TOP, -1, 0, 0);
      offer_op(OP_FARTHEST, 0, 0, 0);
      offer_op(OP_NEAREST, 0, 0, 0);
      offer_op(OP_POP_BOTTOM, 0, 0, 0);
      offer_op(OP_POP_TOP, 0, 0, 0);
      // equal distances left: the one nearer the bottom wins both ways
      offer_op(OP_FARTHEST, 0, 0, 0);
      offer_op(OP_NEAREST, 0, 0, 0);
      offer_op(OP_POP_TOP, 0, 0, 0);
      offer_op(OP_LENGTH, 0, 0, 0);
      offer_op(OP_CLEAR, 0, 0, 0);
      offer_op(OP_LENGTH, 0, 0, 0);
      offer_op(OP_POP_TOP, 0, 0, 0);
      offer_op(OP_FARTHEST, 0, 0, 0);
   endtask

   initial begin : stimulus
      logic [CSR_W-1:0] lo;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_mix(ITEMS_PER_PHASE);
      for (int p = 0; p < 6; p++) begin
         drain_and_wait(25);
         case (p)
            0: write_bounds(16'd0, 16'hffff);
            1: write_bounds(16'hffff, 16'd0);
            2: write_bounds(16'd10, 16'd1000);
            3: write_bounds(16'd50, 16'd52);
            4: write_bounds(16'd100, 16'd100);
            default: begin
               lo = 16'($urandom_range(3000));
               write_bounds(lo, lo + 16'($urandom_range(3000)));
            end
         endcase
         run_mix(ITEMS_PER_PHASE);
      end
      drain_and_wait(30);
      if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
         $display("point_deque_nearest_farthest_core_test: clean");
      end else begin
         $display("point_deque_nearest_farthest_core_test: errors");
      end
      $finish;
   end

endmodule

@@ point_deque_nearest_farthest_core.f @@
src/pdnf_pkg.sv
src/pdnf_dist.sv
src/point_deque_nearest_farthest_core.sv
bench/point_deque_nearest_farthest_core_test.sv
